// ===== design/cmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// cmmd_pkg: shared types and arithmetic for the column min-max decimator
// Holds widths, register indexes, transaction types and the fixed-point
// helpers that turn a Q34.32 product-plus-offset sum into a pixel coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

package cmmd_pkg;

  // Data and pixel widths.
  localparam int DATA_WIDTH  = 32;
  localparam int PIXEL_WIDTH = 16;
  localparam int CFG_WIDTH   = 32;
  localparam int FRAC_BITS   = 16;

  // A product of a sample and a gain is Q32.32; the offset sum needs two guard bits.
  localparam int PROD_WIDTH = DATA_WIDTH + CFG_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;
  localparam int INT_WIDTH  = SUM_WIDTH - 2 * FRAC_BITS;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_GAIN   = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_OFFSET = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_GAIN   = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_OFFSET = CFG_INDEX_WIDTH'(3);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECIMATE = CFG_INDEX_WIDTH'(4);

  // Result kinds.
  localparam logic KIND_SPAN    = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // Queue sizes between front and back, and in front of the result port.
  localparam int JQ_DEPTH     = 8;
  localparam int JQ_PTR_WIDTH = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_WIDTH = $clog2(JQ_DEPTH + 1);
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_PTR_WIDTH = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_WIDTH = $clog2(OQ_DEPTH + 1);

  // Saturation bounds of a pixel coordinate at integer-part width.
  localparam logic signed [INT_WIDTH-1:0] PIX_HI = INT_WIDTH'((1 << (PIXEL_WIDTH - 1)) - 1);
  localparam logic signed [INT_WIDTH-1:0] PIX_LO = INT_WIDTH'(-(1 << (PIXEL_WIDTH - 1)));

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         first_sample;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic                          seg_kind;
    logic signed [PIXEL_WIDTH-1:0] start_col;
    logic signed [PIXEL_WIDTH-1:0] start_row;
    logic signed [PIXEL_WIDTH-1:0] end_col;
    logic signed [PIXEL_WIDTH-1:0] end_row;
    logic                          last_segment;
  } out_item_t;

  typedef struct packed {
    logic signed [CFG_WIDTH-1:0] x_gain;
    logic signed [CFG_WIDTH-1:0] x_offset;
    logic signed [CFG_WIDTH-1:0] y_gain;
    logic signed [CFG_WIDTH-1:0] y_offset;
    logic                        decimate_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_gain:          CFG_WIDTH'(65536),
    x_offset:        '0,
    y_gain:          CFG_WIDTH'(-65536),
    y_offset:        '0,
    decimate_enable: 1'b1
  };

  // One closed column handed from the front to the back.
  typedef struct packed {
    logic                          span_check;
    logic signed [PIXEL_WIDTH-1:0] cur_col;
    logic signed [DATA_WIDTH-1:0]  col_min;
    logic signed [DATA_WIDTH-1:0]  col_max;
    logic signed [DATA_WIDTH-1:0]  prev_y;
    logic signed [PIXEL_WIDTH-1:0] new_col;
    logic signed [DATA_WIDTH-1:0]  cur_y;
  } job_t;

  // Write side of the result queue: zero, one or two results per cycle.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } oq_wr_t;

  // Product plus offset, both brought to Q32.32.
  function automatic logic signed [SUM_WIDTH-1:0] scaled_sum(
    input logic signed [PROD_WIDTH-1:0] prod,
    input logic signed [CFG_WIDTH-1:0]  offset
  );
    logic signed [SUM_WIDTH-1:0] off_ext;
    logic signed [SUM_WIDTH-1:0] prod_ext;
    off_ext  = SUM_WIDTH'(offset) <<< FRAC_BITS;
    prod_ext = SUM_WIDTH'(prod);
    return prod_ext + off_ext;
  endfunction

  // Integer part rounded toward minus infinity.
  function automatic logic signed [INT_WIDTH-1:0] floor_part(
    input logic signed [SUM_WIDTH-1:0] sum
  );
    return sum[SUM_WIDTH-1 -: INT_WIDTH];
  endfunction

  // Integer part truncated toward zero, saturated to the pixel range.
  function automatic logic signed [PIXEL_WIDTH-1:0] pixel_of(
    input logic signed [SUM_WIDTH-1:0] sum
  );
    logic signed [INT_WIDTH-1:0] fl;
    logic signed [INT_WIDTH-1:0] tr;
    logic                        round_up;
    fl       = sum[SUM_WIDTH-1 -: INT_WIDTH];
    round_up = sum[SUM_WIDTH-1] && (sum[2*FRAC_BITS-1:0] != '0);
    tr       = fl + {{(INT_WIDTH-1){1'b0}}, round_up};
    if (tr > PIX_HI) begin
      return PIX_HI[PIXEL_WIDTH-1:0];
    end else if (tr < PIX_LO) begin
      return PIX_LO[PIXEL_WIDTH-1:0];
    end
    return tr[PIXEL_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/cmmd_job_queue.sv =====
// ----------------------------------------------------------------------------
// cmmd_job_queue: queue of closed columns between front and back
// A small register queue that lets the classifier and the span/segment
// builder stall independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module cmmd_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cmmd_pkg::job_t push_data,
  input  logic           pop,
  output logic           empty,
  output cmmd_pkg::job_t head
);
  import cmmd_pkg::*;

  job_t                    mem_r [JQ_DEPTH];
  logic [JQ_PTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JQ_PTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JQ_CNT_WIDTH-1:0] count_r, count_nxt;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + JQ_PTR_WIDTH'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + JQ_PTR_WIDTH'(1) : rd_ptr_r;
    count_nxt  = count_r + JQ_CNT_WIDTH'(push) - JQ_CNT_WIDTH'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/cmmd_front.sv =====
// ----------------------------------------------------------------------------
// cmmd_front: sample intake and column classifier
// Registers each sample, maps x to a pixel column over two pipeline stages,
// then folds it into the running column extremes or closes the column and
// hands a job to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cmmd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  cmmd_pkg::in_item_t in_data,
  output logic               in_full,
  input  cmmd_pkg::cfg_t     cfg,
  input  logic               jq_pop,
  output logic               jq_push,
  output cmmd_pkg::job_t     jq_data
);
  import cmmd_pkg::*;

  logic [JQ_CNT_WIDTH-1:0] credit_r, credit_nxt;
  logic                    accept;
  logic                    drop;

  logic     s0_valid_r;
  in_item_t s0_item_r;

  logic                         s1_valid_r;
  logic signed [PROD_WIDTH-1:0] s1_prod_r;
  logic signed [DATA_WIDTH-1:0] s1_y_r;
  logic                         s1_first_r;
  logic                         s1_last_r;

  logic signed [SUM_WIDTH-1:0]   s1_sum;
  logic                          s2_valid_r;
  logic signed [INT_WIDTH-1:0]   s2_floor_r;
  logic signed [PIXEL_WIDTH-1:0] s2_col_r;
  logic signed [DATA_WIDTH-1:0]  s2_y_r;
  logic                          s2_first_r;
  logic                          s2_last_r;

  logic signed [PIXEL_WIDTH-1:0] cur_col_r, cur_col_nxt;
  logic signed [DATA_WIDTH-1:0]  col_min_r, col_min_nxt;
  logic signed [DATA_WIDTH-1:0]  col_max_r, col_max_nxt;
  logic signed [DATA_WIDTH-1:0]  prev_y_r, prev_y_nxt;
  logic                          open_r, open_nxt;
  logic                          new_col;

  // Every accepted sample holds one credit until it is folded away or its
  // job leaves the queue, so the queue can never overflow.
  assign accept     = in_push && !in_full;
  assign in_full    = (credit_r == JQ_CNT_WIDTH'(JQ_DEPTH));
  assign credit_nxt = credit_r + JQ_CNT_WIDTH'(accept) - JQ_CNT_WIDTH'(drop)
                      - JQ_CNT_WIDTH'(jq_pop);

  // Pipeline valid bits and credit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r   <= '0;
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      open_r     <= 1'b0;
    end else begin
      credit_r   <= credit_nxt;
      s0_valid_r <= accept;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      open_r     <= open_nxt;
    end
  end

  // Stage 0 captures the transaction; stage 1 forms x times gain.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_item_r <= in_data;
    end
    s1_prod_r  <= PROD_WIDTH'(s0_item_r.x_value) * PROD_WIDTH'(cfg.x_gain);
    s1_y_r     <= s0_item_r.y_value;
    s1_first_r <= s0_item_r.first_sample;
    s1_last_r  <= s0_item_r.last_sample;
  end

  // Stage 2 adds the offset and keeps both the floor and the saturated column.
  assign s1_sum = scaled_sum(s1_prod_r, cfg.x_offset);

  always_ff @(posedge clk) begin
    s2_floor_r <= floor_part(s1_sum);
    s2_col_r   <= pixel_of(s1_sum);
    s2_y_r     <= s1_y_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // Column classifier: open a trace, fold into the column, or close it.
  assign new_col = s2_floor_r > INT_WIDTH'(cur_col_r);

  always_comb begin
    cur_col_nxt = cur_col_r;
    col_min_nxt = col_min_r;
    col_max_nxt = col_max_r;
    prev_y_nxt  = prev_y_r;
    open_nxt    = open_r;
    jq_push     = 1'b0;
    drop        = 1'b0;

    jq_data.span_check = cfg.decimate_enable;
    jq_data.cur_col    = cur_col_r;
    jq_data.col_min    = col_min_r;
    jq_data.col_max    = col_max_r;
    jq_data.prev_y     = prev_y_r;
    jq_data.new_col    = s2_col_r;
    jq_data.cur_y      = s2_y_r;

    if (s2_valid_r) begin
      priority if (s2_first_r || !open_r) begin
        cur_col_nxt = s2_col_r;
        col_min_nxt = s2_y_r;
        col_max_nxt = s2_y_r;
        prev_y_nxt  = s2_y_r;
        open_nxt    = !s2_last_r;
        drop        = 1'b1;
      end else if (cfg.decimate_enable && !new_col && !s2_last_r) begin
        if (s2_y_r > col_max_r) begin
          col_max_nxt = s2_y_r;
        end
        if (s2_y_r < col_min_r) begin
          col_min_nxt = s2_y_r;
        end
        prev_y_nxt = s2_y_r;
        drop       = 1'b1;
      end else begin
        jq_push     = 1'b1;
        cur_col_nxt = s2_col_r;
        col_min_nxt = s2_y_r;
        col_max_nxt = s2_y_r;
        prev_y_nxt  = s2_y_r;
        if (s2_last_r) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  // Column state; only read once a trace has been opened and seeded.
  always_ff @(posedge clk) begin
    cur_col_r <= cur_col_nxt;
    col_min_r <= col_min_nxt;
    col_max_r <= col_max_nxt;
    prev_y_r  <= prev_y_nxt;
  end

endmodule

`default_nettype wire

// ===== design/cmmd_back.sv =====
// ----------------------------------------------------------------------------
// cmmd_back: span and segment builder
// Takes closed columns from the job queue, scales the stored y values to
// rows, tests the span height and writes one or two results to the result
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cmmd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cmmd_pkg::cfg_t   cfg,
  input  logic             jq_empty,
  input  cmmd_pkg::job_t   jq_data,
  output logic             jq_pop,
  input  logic             out_take,
  output cmmd_pkg::oq_wr_t oq_wr
);
  import cmmd_pkg::*;

  logic [OQ_CNT_WIDTH-1:0] resv_r, resv_nxt;

  logic [DATA_WIDTH-1:0] col_diff;
  logic [CFG_WIDTH-1:0]  y_mag;

  logic                          b1_valid_r;
  logic                          b1_span_check_r;
  logic signed [PIXEL_WIDTH-1:0] b1_cur_col_r;
  logic signed [PIXEL_WIDTH-1:0] b1_new_col_r;
  logic signed [PROD_WIDTH-1:0]  b1_min_prod_r;
  logic signed [PROD_WIDTH-1:0]  b1_max_prod_r;
  logic signed [PROD_WIDTH-1:0]  b1_prev_prod_r;
  logic signed [PROD_WIDTH-1:0]  b1_y_prod_r;
  logic [PROD_WIDTH-1:0]         b1_span_prod_r;

  logic      visible;
  out_item_t span_item;
  out_item_t seg_item;

  // Each popped job reserves two result slots; an unused one is returned
  // when the span is not drawn.
  assign jq_pop   = !jq_empty && (resv_r <= OQ_CNT_WIDTH'(OQ_DEPTH - 2));
  assign resv_nxt = resv_r + (jq_pop ? OQ_CNT_WIDTH'(2) : '0)
                    - OQ_CNT_WIDTH'(b1_valid_r && !visible) - OQ_CNT_WIDTH'(out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resv_r     <= '0;
      b1_valid_r <= 1'b0;
    end else begin
      resv_r     <= resv_nxt;
      b1_valid_r <= jq_pop;
    end
  end

  // Height of the span in data units and gain magnitude for the height test.
  assign col_diff = jq_data.col_max - jq_data.col_min;
  assign y_mag    = cfg.y_gain[CFG_WIDTH-1] ? -cfg.y_gain : cfg.y_gain;

  // Multiply stage: all four y values and the span height, in parallel.
  always_ff @(posedge clk) begin
    if (jq_pop) begin
      b1_span_check_r <= jq_data.span_check;
      b1_cur_col_r    <= jq_data.cur_col;
      b1_new_col_r    <= jq_data.new_col;
      b1_min_prod_r   <= PROD_WIDTH'(jq_data.col_min) * PROD_WIDTH'(cfg.y_gain);
      b1_max_prod_r   <= PROD_WIDTH'(jq_data.col_max) * PROD_WIDTH'(cfg.y_gain);
      b1_prev_prod_r  <= PROD_WIDTH'(jq_data.prev_y) * PROD_WIDTH'(cfg.y_gain);
      b1_y_prod_r     <= PROD_WIDTH'(jq_data.cur_y) * PROD_WIDTH'(cfg.y_gain);
      b1_span_prod_r  <= PROD_WIDTH'(col_diff) * PROD_WIDTH'(y_mag);
    end
  end

  // The span is drawn when span checking is on and its scaled height reaches one pixel.
  assign visible = b1_span_check_r && (b1_span_prod_r[PROD_WIDTH-1:2*FRAC_BITS] != '0);

  // Row stage: add offsets, truncate and saturate, then assemble results.
  always_comb begin
    span_item.seg_kind     = KIND_SPAN;
    span_item.start_col    = b1_cur_col_r;
    span_item.start_row    = pixel_of(scaled_sum(b1_min_prod_r, cfg.y_offset));
    span_item.end_col      = b1_cur_col_r;
    span_item.end_row      = pixel_of(scaled_sum(b1_max_prod_r, cfg.y_offset));
    span_item.last_segment = 1'b0;

    seg_item.seg_kind      = KIND_SEGMENT;
    seg_item.start_col     = b1_cur_col_r;
    seg_item.start_row     = pixel_of(scaled_sum(b1_prev_prod_r, cfg.y_offset));
    seg_item.end_col       = b1_new_col_r;
    seg_item.end_row       = pixel_of(scaled_sum(b1_y_prod_r, cfg.y_offset));
    seg_item.last_segment  = 1'b1;

    oq_wr.item0 = visible ? span_item : seg_item;
    oq_wr.item1 = seg_item;
    if (!b1_valid_r) begin
      oq_wr.count = 2'd0;
    end else if (visible) begin
      oq_wr.count = 2'd2;
    end else begin
      oq_wr.count = 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== design/cmmd_out_queue.sv =====
// ----------------------------------------------------------------------------
// cmmd_out_queue: result queue in front of the output port
// Takes up to two results per cycle from the builder and presents the oldest
// one on the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmmd_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cmmd_pkg::oq_wr_t    wr,
  input  logic                rd_take,
  output logic                empty,
  output cmmd_pkg::out_item_t head
);
  import cmmd_pkg::*;

  out_item_t               mem_r [OQ_DEPTH];
  logic [OQ_PTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_WIDTH-1:0] count_r, count_nxt;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_WIDTH'(wr.count);
    rd_ptr_nxt = rd_take ? rd_ptr_r + OQ_PTR_WIDTH'(1) : rd_ptr_r;
    count_nxt  = count_r + OQ_CNT_WIDTH'(wr.count) - OQ_CNT_WIDTH'(rd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: the second result of a pair lands in the following slot.
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem_r[wr_ptr_r] <= wr.item0;
    end
    if (wr.count == 2'd2) begin
      mem_r[wr_ptr_r + OQ_PTR_WIDTH'(1)] <= wr.item1;
    end
  end

  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/column_min_max_decimator.sv =====
// ----------------------------------------------------------------------------
// column_min_max_decimator: X-sorted trace to pixel segments
// Top level: configuration registers, front classifier, job queue, span and
// segment builder, and result queue.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock while in_full is low and delivers
// at most one result per clock. A sample that folds into a column or opens
// a trace yields no result; a sample that closes a column yields a
// connecting segment, preceded by a min-max span when span checking is on
// and that span is at least one pixel tall. An accepted sample passes the
// front pipeline (capture, x multiply, offset and saturation,
// classification into the job queue) and then the back (y multiplies, then
// row scaling into the result queue) on its way to the output. The
// sustained rate is one sample per cycle as long as results are popped;
// when most samples close a column with a visible span, the single result
// port limits the rate, as such a sample gives two results. The configuration
// port is always ready; write it only while no samples are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module column_min_max_decimator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  input  cmmd_pkg::in_item_t                     in_data,
  output logic                                   in_full,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output cmmd_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cmmd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [cmmd_pkg::CFG_WIDTH-1:0]         cfg_data
);
  import cmmd_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   jq_push;
  job_t   jq_push_data;
  logic   jq_pop;
  logic   jq_empty;
  job_t   jq_head;
  oq_wr_t oq_wr;
  logic   out_take;

  // Configuration registers; writes past the register list are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_GAIN:   cfg_nxt.x_gain          = cfg_data;
        REG_X_OFFSET: cfg_nxt.x_offset        = cfg_data;
        REG_Y_GAIN:   cfg_nxt.y_gain          = cfg_data;
        REG_Y_OFFSET: cfg_nxt.y_offset        = cfg_data;
        REG_DECIMATE: cfg_nxt.decimate_enable = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A result transaction completes when the consumer pops a waiting result.
  assign out_take = out_pop && !out_empty;

  cmmd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .cfg     (cfg_r),
    .jq_pop  (jq_pop),
    .jq_push (jq_push),
    .jq_data (jq_push_data)
  );

  cmmd_job_queue u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (jq_push),
    .push_data (jq_push_data),
    .pop       (jq_pop),
    .empty     (jq_empty),
    .head      (jq_head)
  );

  cmmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .jq_empty (jq_empty),
    .jq_data  (jq_head),
    .jq_pop   (jq_pop),
    .out_take (out_take),
    .oq_wr    (oq_wr)
  );

  cmmd_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (oq_wr),
    .rd_take (out_take),
    .empty   (out_empty),
    .head    (out_data)
  );

endmodule

`default_nettype wire
